>>> hw/rtl/nfi_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes of the Newton forward-difference interpolator.
package nfi_pkg;

  localparam int MAX_POINTS = 8;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;

  localparam int DATA_W     = 32;
  localparam int DEG_W      = 3;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Forward differences grow by one bit per order.
  localparam int DIF_W      = DATA_W + MAX_POINTS;
  // Spacing check: x values, h and i*h.
  localparam int SP_W       = DATA_W + IDX_W + 5;
  localparam int RES_W      = 64;
  localparam int TMAG_W     = 62;
  localparam int ACC_W      = 96;
  // Divider: |a| <= 2^46 shifted left by 16, divided by k*h.
  localparam int DIVD_W     = 63;
  localparam int DIVS_W     = DATA_W + IDX_W;
  localparam int DIV_CNT_W  = $clog2(DIVD_W);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_EVAL  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_UNEVEN    = 2'd2,
    ST_SAT       = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 1'b1;

  localparam logic [DATA_W-1:0] I32_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] I32_MIN = 32'h8000_0000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SORT_FIRST, S_SORT_CMP, S_SORT_WB,
    S_SP_X0, S_SP_X1, S_SP_ACC, S_SP_CHK, S_SP_END,
    S_DF_START, S_DF_FIRST, S_DF_STEP,
    S_CF_START, S_CF_LOAD, S_CF_CHK, S_CF_DIV, S_CF_WR,
    S_EV_C0, S_EV_CRD, S_EV_CI, S_EV_XRD, S_EV_B,
    S_EV_M0, S_EV_M1, S_EV_M2, S_EV_M3, S_EV_M4,
    S_EV_ADD, S_EV_DONE, S_RESULT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hw/rtl/nfi_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command input and the result output.
interface nfi_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic signed [nfi_pkg::DATA_W-1:0]   x_value;
  logic signed [nfi_pkg::DATA_W-1:0]   y_value;

  modport source (output valid, cmd, x_value, y_value, input ready);
  modport sink   (input valid, cmd, x_value, y_value, output ready);
endinterface

interface nfi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [nfi_pkg::DATA_W-1:0]   value;
  logic [1:0]                          status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

>>> hw/rtl/newton_forward_interpolator.sv
`timescale 1ns / 1ps
// Top level of the Newton forward-difference interpolator.
//
//  Channel   Direction  Beat contents
//  in_ch     sink       cmd (load / evaluate / clear), x_value, y_value
//  out_ch    source     value, status (one beat per evaluate command)
//  cfg       write      cfg_we_i, cfg_idx_i (degree, tolerance), cfg_data_i
//
// The beat that loads the last point starts the set-up: a bubble sort, the
// spacing check, the difference table and the coefficients, with up to
// n*(n+1)/2 divisions for degree n. The set-up time is set by the restoring
// divider, one quotient bit a cycle. The time an evaluate beat takes is set
// by the shared 32x32 multiplier. in_ch.ready is high only while the
// sequencer is idle; a result waiting in the output register does not hold
// the input back until a further result has to be placed.
// Reset leaves degree 1, tolerance 1 and no points loaded; there is no
// clearing pass.
module newton_forward_interpolator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  nfi_in_if.sink                              in_ch,
  nfi_out_if.source                           out_ch,
  input  logic                                cfg_we_i,
  input  logic [nfi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [nfi_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int IW = nfi_pkg::IDX_W;
  localparam int CW = nfi_pkg::CNT_W;
  localparam int DW = nfi_pkg::DATA_W;
  localparam int FW = nfi_pkg::DIF_W;
  localparam int SW = nfi_pkg::SP_W;
  localparam int RW = nfi_pkg::RES_W;
  localparam int TW = nfi_pkg::TMAG_W;
  localparam int AW = nfi_pkg::ACC_W;

  localparam logic signed [RW-1:0] LIM61   = 64'sh2000_0000_0000_0000;
  localparam logic [RW-1:0]        LIM46   = 64'h0000_4000_0000_0000;
  localparam logic signed [RW-1:0] I32MAX64 = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [RW-1:0] I32MIN64 = -64'sh0000_0000_8000_0000;

  // Saturates a wide signed value to 32 bits.
  function automatic logic [DW-1:0] sat32(input logic signed [RW-1:0] v);
    logic [DW-1:0] r;
    if (v > I32MAX64) begin
      r = nfi_pkg::I32_MAX;
    end else if (v < I32MIN64) begin
      r = nfi_pkg::I32_MIN;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // Sample and coefficient stores.
  logic signed [DW-1:0] px_mem  [nfi_pkg::MAX_POINTS];
  logic signed [FW-1:0] dif_mem [nfi_pkg::MAX_POINTS];
  logic signed [DW-1:0] cf_mem  [nfi_pkg::MAX_POINTS];

  nfi_pkg::state_e state_q, state_d;

  logic [nfi_pkg::DEG_W-1:0] degree_q, degree_d;
  logic [nfi_pkg::TOL_W-1:0] tol_q, tol_d;
  logic [CW-1:0]             loaded_q, loaded_d;
  logic                      rdy_q, rdy_d;
  logic                      spok_q, spok_d;
  logic                      ok_q, ok_d;
  logic [IW-1:0]             i_q, i_d;
  logic [IW-1:0]             j_q, j_d;
  logic [CW-1:0]             k_q, k_d;

  logic signed [DW-1:0]      cur_x_q, cur_x_d;
  logic signed [FW-1:0]      cur_d_q, cur_d_d;
  logic signed [DW-1:0]      x0_q, x0_d;
  logic signed [DW:0]        h_q, h_d;
  logic signed [SW-1:0]      ih_q, ih_d;
  logic signed [RW-1:0]      a_q, a_d;
  logic [nfi_pkg::DIVS_W-1:0] kh_q, kh_d;
  logic                      s_q, s_d;
  logic signed [DW-1:0]      xev_q, xev_d;
  logic [TW-1:0]             tmag_q, tmag_d;
  logic                      tneg_q, tneg_d;
  logic [DW:0]               bmag_q, bmag_d;
  logic [2*DW-1:0]           p_q, p_d;
  logic [AW-1:0]             acc_q, acc_d;
  logic                      sat_q, sat_d;
  logic signed [RW-1:0]      res_q, res_d;
  logic [DW-1:0]             pend_val_q, pend_val_d;
  nfi_pkg::status_e          pend_st_q, pend_st_d;

  logic                      out_valid_q, out_valid_d;
  logic [DW-1:0]             out_val_q, out_val_d;
  logic [1:0]                out_st_q, out_st_d;

  // Memory ports.
  logic [IW-1:0]             rd_addr;
  logic [IW-1:0]             cf_rd_addr;
  logic signed [DW-1:0]      rdx_q;
  logic signed [FW-1:0]      rdd_q;
  logic signed [DW-1:0]      cf_rd_q;
  logic                      px_we, dif_we, cf_we;
  logic [IW-1:0]             wr_addr;
  logic signed [DW-1:0]      wr_x;
  logic signed [FW-1:0]      wr_d;
  logic [DW-1:0]             cf_wdata;

  // Derived values.
  logic [nfi_pkg::DEG_W-1:0] deg_clip;
  logic [IW-1:0]             n_eff;
  logic [CW-1:0]             np;
  logic                      in_acc;
  logic                      out_free;
  logic signed [DW:0]        h_new;
  logic signed [SW-1:0]      dev;
  logic [SW-1:0]             dev_abs;
  logic [RW-1:0]             a_abs;
  logic signed [RW-1:0]      q_s;
  logic signed [DW:0]        b_val;
  logic [DW-1:0]             cf_abs;
  logic [DW-1:0]             mul_a;
  logic [2*DW-1:0]           mul_p;
  logic signed [RW-1:0]      t_s;
  logic signed [RW-1:0]      sum;

  nfi_pkg::div_req_t div_req;
  nfi_pkg::div_rsp_t div_rsp;

  nfi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign deg_clip = (degree_q == '0) ? nfi_pkg::DEG_W'(1) : degree_q;
  assign n_eff    = (int'(deg_clip) > nfi_pkg::MAX_POINTS - 1) ?
                    IW'(nfi_pkg::MAX_POINTS - 1) : IW'(deg_clip);
  assign np       = CW'(n_eff) + CW'(1);

  assign in_ch.ready  = (state_q == nfi_pkg::S_IDLE);
  assign in_acc       = in_ch.valid && (state_q == nfi_pkg::S_IDLE);
  assign out_free     = !out_valid_q || out_ch.ready;
  assign out_ch.valid = out_valid_q;
  assign out_ch.value = out_val_q;
  assign out_ch.status = out_st_q;

  assign h_new   = DW'(rdx_q) - DW'(x0_q) + (DW + 1)'(0) ;
  assign dev     = SW'(rdx_q) - SW'(x0_q) - ih_q;
  assign dev_abs = dev[SW-1] ? SW'(-dev) : SW'(dev);
  assign a_abs   = a_q[RW-1] ? RW'(-a_q) : RW'(a_q);
  assign q_s     = a_q[RW-1] ? -$signed({1'b0, div_rsp.quotient})
                             : $signed({1'b0, div_rsp.quotient});
  assign b_val   = (DW + 1)'(xev_q) - (DW + 1)'(rdx_q);
  assign cf_abs  = cf_rd_q[DW-1] ? DW'(-cf_rd_q) : DW'(cf_rd_q);
  assign mul_a   = (state_q == nfi_pkg::S_EV_M0) ? tmag_q[DW-1:0]
                                                 : DW'(tmag_q[TW-1:DW]);
  assign mul_p   = mul_a * bmag_q[DW-1:0];
  assign t_s     = tneg_q ? -$signed(RW'(tmag_q)) : $signed(RW'(tmag_q));
  assign sum     = res_q + t_s;

  // Sequencer: next state, datapath register updates and memory strobes.
  always_comb begin
    state_d    = state_q;
    degree_d   = degree_q;
    tol_d      = tol_q;
    loaded_d   = loaded_q;
    rdy_d      = rdy_q;
    spok_d     = spok_q;
    ok_d       = ok_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    cur_x_d    = cur_x_q;
    cur_d_d    = cur_d_q;
    x0_d       = x0_q;
    h_d        = h_q;
    ih_d       = ih_q;
    a_d        = a_q;
    kh_d       = kh_q;
    s_d        = s_q;
    xev_d      = xev_q;
    tmag_d     = tmag_q;
    tneg_d     = tneg_q;
    bmag_d     = bmag_q;
    p_d        = p_q;
    acc_d      = acc_q;
    sat_d      = sat_q;
    res_d      = res_q;
    pend_val_d = pend_val_q;
    pend_st_d  = pend_st_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_val_d  = out_val_q;
    out_st_d   = out_st_q;
    rd_addr    = '0;
    cf_rd_addr = '0;
    px_we      = 1'b0;
    dif_we     = 1'b0;
    cf_we      = 1'b0;
    wr_addr    = '0;
    wr_x       = cur_x_q;
    wr_d       = cur_d_q;
    cf_wdata   = '0;
    div_req.start    = 1'b0;
    div_req.dividend = {a_abs[46:0], 16'b0};
    div_req.divisor  = kh_q;

    unique case (state_q)
      nfi_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_ch.cmd)
            nfi_pkg::CMD_LOAD: begin
              if (!rdy_q && (loaded_q < np)) begin
                px_we    = 1'b1;
                dif_we   = 1'b1;
                wr_addr  = loaded_q[IW-1:0];
                wr_x     = in_ch.x_value;
                wr_d     = FW'(in_ch.y_value);
                loaded_d = loaded_q + CW'(1);
                if (loaded_q + CW'(1) == np) begin
                  // Point 0 is being read this cycle; the sort starts next.
                  i_d     = n_eff;
                  j_d     = '0;
                  state_d = nfi_pkg::S_SORT_FIRST;
                end
              end
            end
            nfi_pkg::CMD_EVAL: begin
              if (!rdy_q) begin
                pend_val_d = '0;
                pend_st_d  = nfi_pkg::ST_NOT_READY;
                state_d    = nfi_pkg::S_RESULT;
              end else if (!spok_q) begin
                pend_val_d = '0;
                pend_st_d  = nfi_pkg::ST_UNEVEN;
                state_d    = nfi_pkg::S_RESULT;
              end else begin
                xev_d   = in_ch.x_value;
                state_d = nfi_pkg::S_EV_C0;
              end
            end
            nfi_pkg::CMD_CLEAR: begin
              loaded_d = '0;
              rdy_d    = 1'b0;
              spok_d   = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      // Bubble sort: the larger element is carried along the pass.
      nfi_pkg::S_SORT_FIRST: begin
        rd_addr = j_q + IW'(1);
        cur_x_d = rdx_q;
        cur_d_d = rdd_q;
        state_d = nfi_pkg::S_SORT_CMP;
      end
      nfi_pkg::S_SORT_CMP: begin
        rd_addr = j_q + IW'(2);
        px_we   = 1'b1;
        dif_we  = 1'b1;
        wr_addr = j_q;
        if (cur_x_q > rdx_q) begin
          wr_x = rdx_q;
          wr_d = rdd_q;
        end else begin
          cur_x_d = rdx_q;
          cur_d_d = rdd_q;
        end
        if (j_q + IW'(1) == i_q) begin
          state_d = nfi_pkg::S_SORT_WB;
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      nfi_pkg::S_SORT_WB: begin
        rd_addr = '0;
        px_we   = 1'b1;
        dif_we  = 1'b1;
        wr_addr = i_q;
        if (i_q == IW'(1)) begin
          state_d = nfi_pkg::S_SP_X0;
        end else begin
          i_d     = i_q - IW'(1);
          j_d     = '0;
          state_d = nfi_pkg::S_SORT_FIRST;
        end
      end

      // Spacing check against x0 + i*h.
      nfi_pkg::S_SP_X0: begin
        rd_addr = IW'(1);
        x0_d    = rdx_q;
        state_d = nfi_pkg::S_SP_X1;
      end
      nfi_pkg::S_SP_X1: begin
        rd_addr = IW'(2);
        h_d     = h_new;
        ih_d    = SW'(h_new);
        ok_d    = (h_new > '0);
        i_d     = IW'(2);
        state_d = (n_eff == IW'(1)) ? nfi_pkg::S_SP_END : nfi_pkg::S_SP_ACC;
      end
      nfi_pkg::S_SP_ACC: begin
        rd_addr = i_q;
        ih_d    = ih_q + SW'(h_q);
        state_d = nfi_pkg::S_SP_CHK;
      end
      nfi_pkg::S_SP_CHK: begin
        rd_addr = i_q + IW'(1);
        if (dev_abs > SW'(tol_q)) begin
          ok_d = 1'b0;
        end
        if (i_q == n_eff) begin
          state_d = nfi_pkg::S_SP_END;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = nfi_pkg::S_SP_ACC;
        end
      end
      nfi_pkg::S_SP_END: begin
        spok_d = ok_q;
        rdy_d  = 1'b1;
        k_d    = CW'(1);
        j_d    = n_eff;
        state_d = ok_q ? nfi_pkg::S_DF_START : nfi_pkg::S_IDLE;
      end

      // Difference table, in place, from the top index down.
      nfi_pkg::S_DF_START: begin
        rd_addr = j_q;
        state_d = nfi_pkg::S_DF_FIRST;
      end
      nfi_pkg::S_DF_FIRST: begin
        rd_addr = j_q - IW'(1);
        cur_d_d = rdd_q;
        state_d = nfi_pkg::S_DF_STEP;
      end
      nfi_pkg::S_DF_STEP: begin
        rd_addr = j_q - IW'(2);
        dif_we  = 1'b1;
        wr_addr = j_q;
        wr_d    = cur_d_q - rdd_q;
        cur_d_d = rdd_q;
        if (CW'(j_q) == k_q) begin
          if (k_q == CW'(n_eff)) begin
            i_d     = '0;
            state_d = nfi_pkg::S_CF_START;
          end else begin
            k_d     = k_q + CW'(1);
            j_d     = n_eff;
            state_d = nfi_pkg::S_DF_START;
          end
        end else begin
          j_d = j_q - IW'(1);
        end
      end

      // Coefficients: up to i divisions by k*h for coefficient i.
      nfi_pkg::S_CF_START: begin
        rd_addr = i_q;
        state_d = nfi_pkg::S_CF_LOAD;
      end
      nfi_pkg::S_CF_LOAD: begin
        a_d     = RW'(rdd_q);
        k_d     = CW'(1);
        kh_d    = nfi_pkg::DIVS_W'(h_q[DW-1:0]);
        s_d     = 1'b0;
        state_d = nfi_pkg::S_CF_CHK;
      end
      nfi_pkg::S_CF_CHK: begin
        if (k_q > CW'(i_q)) begin
          state_d = nfi_pkg::S_CF_WR;
        end else if (a_abs > LIM46) begin
          s_d     = 1'b1;
          state_d = nfi_pkg::S_CF_WR;
        end else begin
          div_req.start = 1'b1;
          state_d       = nfi_pkg::S_CF_DIV;
        end
      end
      nfi_pkg::S_CF_DIV: begin
        if (div_rsp.done) begin
          a_d     = q_s;
          k_d     = k_q + CW'(1);
          kh_d    = kh_q + nfi_pkg::DIVS_W'(h_q[DW-1:0]);
          state_d = nfi_pkg::S_CF_CHK;
        end
      end
      nfi_pkg::S_CF_WR: begin
        cf_we = 1'b1;
        if (s_q) begin
          cf_wdata = a_q[RW-1] ? nfi_pkg::I32_MIN : nfi_pkg::I32_MAX;
        end else begin
          cf_wdata = sat32(a_q);
        end
        if (i_q == n_eff) begin
          state_d = nfi_pkg::S_IDLE;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = nfi_pkg::S_CF_START;
        end
      end

      // Evaluation: sum of a[i] times the product of (x - x[j]).
      nfi_pkg::S_EV_C0: begin
        res_d   = RW'(cf_rd_q);
        i_d     = IW'(1);
        sat_d   = 1'b0;
        state_d = nfi_pkg::S_EV_CRD;
      end
      nfi_pkg::S_EV_CRD: begin
        cf_rd_addr = i_q;
        state_d    = nfi_pkg::S_EV_CI;
      end
      nfi_pkg::S_EV_CI: begin
        tmag_d  = TW'(cf_abs);
        tneg_d  = cf_rd_q[DW-1];
        j_d     = '0;
        state_d = nfi_pkg::S_EV_XRD;
      end
      nfi_pkg::S_EV_XRD: begin
        rd_addr = j_q;
        state_d = nfi_pkg::S_EV_B;
      end
      nfi_pkg::S_EV_B: begin
        bmag_d  = b_val[DW] ? (DW + 1)'(-b_val) : (DW + 1)'(b_val);
        tneg_d  = tneg_q ^ b_val[DW];
        state_d = nfi_pkg::S_EV_M0;
      end
      nfi_pkg::S_EV_M0: begin
        p_d     = mul_p;
        state_d = nfi_pkg::S_EV_M1;
      end
      nfi_pkg::S_EV_M1: begin
        acc_d   = AW'(p_q);
        p_d     = mul_p;
        state_d = nfi_pkg::S_EV_M2;
      end
      nfi_pkg::S_EV_M2: begin
        acc_d   = acc_q + {p_q, {DW{1'b0}}};
        state_d = nfi_pkg::S_EV_M3;
      end
      nfi_pkg::S_EV_M3: begin
        if (bmag_q[DW]) begin
          acc_d = acc_q + {{(AW - TW - DW){1'b0}}, tmag_q, {DW{1'b0}}};
        end
        state_d = nfi_pkg::S_EV_M4;
      end
      nfi_pkg::S_EV_M4: begin
        if (acc_q[AW-1:77] != '0) begin
          tmag_d = TW'(LIM61);
          sat_d  = 1'b1;
        end else begin
          tmag_d = TW'(acc_q[76:16]);
        end
        if (CW'(j_q) + CW'(1) == CW'(i_q)) begin
          state_d = nfi_pkg::S_EV_ADD;
        end else begin
          j_d     = j_q + IW'(1);
          state_d = nfi_pkg::S_EV_XRD;
        end
      end
      nfi_pkg::S_EV_ADD: begin
        if (sum > LIM61) begin
          res_d = LIM61;
          sat_d = 1'b1;
        end else if (sum < -LIM61) begin
          res_d = -LIM61;
          sat_d = 1'b1;
        end else begin
          res_d = sum;
        end
        if (i_q == n_eff) begin
          state_d = nfi_pkg::S_EV_DONE;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = nfi_pkg::S_EV_CRD;
        end
      end
      nfi_pkg::S_EV_DONE: begin
        if (sat_q) begin
          pend_val_d = res_q[RW-1] ? nfi_pkg::I32_MIN : nfi_pkg::I32_MAX;
          pend_st_d  = nfi_pkg::ST_SAT;
        end else if ((res_q > I32MAX64) || (res_q < I32MIN64)) begin
          pend_val_d = sat32(res_q);
          pend_st_d  = nfi_pkg::ST_SAT;
        end else begin
          pend_val_d = res_q[DW-1:0];
          pend_st_d  = nfi_pkg::ST_OK;
        end
        state_d = nfi_pkg::S_RESULT;
      end

      // Hand the result to the output register once it is free.
      nfi_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = pend_val_q;
          out_st_d    = pend_st_q;
          state_d     = nfi_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = nfi_pkg::S_IDLE;
      end
    endcase

    // The user must write the registers only while the sequencer is idle; the block does not enforce it.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nfi_pkg::CFG_DEGREE: begin
          degree_d = cfg_data_i[nfi_pkg::DEG_W-1:0];
          loaded_d = '0;
          rdy_d    = 1'b0;
          spok_d   = 1'b1;
        end
        nfi_pkg::CFG_TOL: begin
          tol_d = cfg_data_i[nfi_pkg::TOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nfi_pkg::S_IDLE;
      degree_q    <= nfi_pkg::DEG_W'(1);
      tol_q       <= nfi_pkg::TOL_W'(1);
      loaded_q    <= '0;
      rdy_q       <= 1'b0;
      spok_q      <= 1'b1;
      ok_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      degree_q    <= degree_d;
      tol_q       <= tol_d;
      loaded_q    <= loaded_d;
      rdy_q       <= rdy_d;
      spok_q      <= spok_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    k_q        <= k_d;
    cur_x_q    <= cur_x_d;
    cur_d_q    <= cur_d_d;
    x0_q       <= x0_d;
    h_q        <= h_d;
    ih_q       <= ih_d;
    a_q        <= a_d;
    kh_q       <= kh_d;
    s_q        <= s_d;
    xev_q      <= xev_d;
    tmag_q     <= tmag_d;
    tneg_q     <= tneg_d;
    bmag_q     <= bmag_d;
    p_q        <= p_d;
    acc_q      <= acc_d;
    sat_q      <= sat_d;
    res_q      <= res_d;
    pend_val_q <= pend_val_d;
    pend_st_q  <= pend_st_d;
    out_val_q  <= out_val_d;
    out_st_q   <= out_st_d;
  end

  always_ff @(posedge clk_i) begin
    if (px_we) begin
      px_mem[wr_addr] <= wr_x;
    end
    if (dif_we) begin
      dif_mem[wr_addr] <= wr_d;
    end
    rdx_q <= px_mem[rd_addr];
    rdd_q <= dif_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cf_we) begin
      cf_mem[i_q] <= cf_wdata;
    end
    cf_rd_q <= cf_mem[cf_rd_addr];
  end

endmodule

>>> hw/rtl/nfi_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module nfi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nfi_pkg::div_req_t  req_i,
  output nfi_pkg::div_rsp_t  rsp_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [nfi_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [nfi_pkg::DIVS_W-1:0]      rem_q;
  logic [nfi_pkg::DIVD_W-1:0]      quo_q;
  logic [nfi_pkg::DIVS_W-1:0]      dvs_q;
  logic [nfi_pkg::DIVS_W:0]        rem_sh;
  logic [nfi_pkg::DIVS_W:0]        rem_sub;
  logic                            ge;

  assign rem_sh  = {rem_q, quo_q[nfi_pkg::DIVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + nfi_pkg::DIV_CNT_W'(1);
      if (cnt_q == nfi_pkg::DIV_CNT_W'(nfi_pkg::DIVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[nfi_pkg::DIVS_W-1:0] : rem_sh[nfi_pkg::DIVS_W-1:0];
      quo_q <= {quo_q[nfi_pkg::DIVD_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> hw/rtl/nfi_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the interpolator, bound to the top level.
module nfi_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [1:0]                   in_cmd_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [nfi_pkg::DATA_W-1:0]   out_value_i,
  input logic [1:0]                   out_status_i
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i) && $stable(out_status_i))
    else $error("result payload changed while stalled");

  // Not-ready and uneven-spacing results carry a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == nfi_pkg::ST_NOT_READY ||
                    out_status_i == nfi_pkg::ST_UNEVEN) |-> out_value_i == '0)
    else $error("error result with non-zero value");

  // A saturated result is one of the two 32-bit limits.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == nfi_pkg::ST_SAT |->
      out_value_i == nfi_pkg::I32_MAX || out_value_i == nfi_pkg::I32_MIN)
    else $error("saturated result not at a limit");

  // An evaluate beat always keeps the sequencer busy for the next cycle.
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_cmd_i == nfi_pkg::CMD_EVAL |=> !in_ready_i)
    else $error("input ready straight after an evaluate beat");

endmodule

bind newton_forward_interpolator nfi_checker u_nfi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .in_cmd_i     (in_ch.cmd),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_value_i  (out_ch.value),
  .out_status_i (out_ch.status)
);

>>> tb/sv/newton_forward_interpolator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Newton forward-difference interpolator.
module newton_forward_interpolator_tb;
  import nfi_pkg::*;

  // A two-bit command code that the block must ignore.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam longint LIM61 = 64'sd1 << 61;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int SETTLE_CYCLES = 2500;
  localparam int ITEM_TARGET = 750;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } beat_t;

  typedef struct packed {
    logic signed [31:0] value;
    status_e            status;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  nfi_in_if  in_ch ();
  nfi_out_if out_ch ();

  newton_forward_interpolator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Beats waiting to be driven and results that the block still owes us.
  beat_t   cmd_backlog[$];
  result_t owed_results[$];
  int      beats_queued;
  int      mismatches;
  bit      no_idle;

  // Shadow copy of the interpolator state, updated as beats are accepted.
  logic [2:0]  sh_degree;
  logic [15:0] sh_tol;
  longint      sh_x[MAX_POINTS];
  longint      sh_y[MAX_POINTS];
  longint      sh_coef[MAX_POINTS];
  int          sh_loaded;
  bit          sh_ready;
  bit          sh_even;
  bit          eval_sat;

  function automatic int point_count();
    int d;
    d = sh_degree;
    if (d < 1) d = 1;
    if (d > MAX_POINTS - 1) d = MAX_POINTS - 1;
    return d + 1;
  endfunction

  function automatic longint clip32(longint v);
    return v > S32_MAX ? S32_MAX : (v < S32_MIN ? S32_MIN : v);
  endfunction

  // Q16.16 product on magnitudes, truncated and limited to 2^61; the limit
  // raises the sticky saturation flag of the current evaluation.
  function automatic longint qmul(longint a, longint b);
    logic [63:0]  ma, mb;
    logic [127:0] prod;
    longint       r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    prod = {64'd0, ma} * {64'd0, mb};
    if (|prod[127:77]) begin
      eval_sat = 1'b1;
      r = LIM61;
    end else begin
      r = longint'(prod[79:16]);
    end
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // Sort, spacing check and coefficient table after the last point arrives.
  function automatic void build_coefficients();
    int     n;
    longint h, dev, tmp, a;
    longint dif[MAX_POINTS];
    bit     ok, s;
    n = point_count() - 1;
    for (int i = n; i >= 1; i--) begin
      for (int j = 0; j < i; j++) begin
        if (sh_x[j] > sh_x[j+1]) begin
          tmp = sh_x[j]; sh_x[j] = sh_x[j+1]; sh_x[j+1] = tmp;
          tmp = sh_y[j]; sh_y[j] = sh_y[j+1]; sh_y[j+1] = tmp;
        end
      end
    end
    h = sh_x[1] - sh_x[0];
    ok = h > 0;
    for (int i = 2; i <= n; i++) begin
      dev = sh_x[i] - sh_x[0] - longint'(i) * h;
      if (dev < 0) dev = -dev;
      if (dev > longint'(sh_tol)) ok = 1'b0;
    end
    sh_even = ok;
    sh_ready = 1'b1;
    if (!ok) return;
    for (int i = 0; i <= n; i++) dif[i] = sh_y[i];
    for (int k = 1; k <= n; k++)
      for (int j = n; j >= k; j--)
        dif[j] -= dif[j-1];
    for (int i = 0; i <= n; i++) begin
      a = dif[i];
      s = 1'b0;
      for (int k = 1; k <= i; k++) begin
        if (a > (64'sd1 <<< 46) || a < -(64'sd1 <<< 46)) begin
          s = 1'b1;
          break;
        end
        a = a * 65536 / (longint'(k) * h);
      end
      sh_coef[i] = s ? (a < 0 ? S32_MIN : S32_MAX) : clip32(a);
    end
  endfunction

  function automatic void apply_beat(beat_t b);
    result_t r;
    longint  acc, t, x;
    int      np;
    np = point_count();
    x = longint'(b.x_value);
    case (b.cmd)
      CMD_LOAD: begin
        if (!sh_ready && sh_loaded < np) begin
          sh_x[sh_loaded] = x;
          sh_y[sh_loaded] = longint'(b.y_value);
          sh_loaded++;
          if (sh_loaded == np) build_coefficients();
        end
      end
      CMD_CLEAR: begin
        sh_loaded = 0;
        sh_ready = 1'b0;
        sh_even = 1'b1;
      end
      CMD_EVAL: begin
        if (!sh_ready) begin
          r = '{value: '0, status: ST_NOT_READY};
        end else if (!sh_even) begin
          r = '{value: '0, status: ST_UNEVEN};
        end else begin
          eval_sat = 1'b0;
          acc = sh_coef[0];
          for (int i = 1; i < np; i++) begin
            t = sh_coef[i];
            for (int j = 0; j < i; j++) t = qmul(t, x - sh_x[j]);
            acc += t;
            if (acc > LIM61) begin acc = LIM61; eval_sat = 1'b1; end
            if (acc < -LIM61) begin acc = -LIM61; eval_sat = 1'b1; end
          end
          r.status = ST_OK;
          if (eval_sat) begin
            acc = acc < 0 ? S32_MIN : S32_MAX;
            r.status = ST_SAT;
          end else if (acc > S32_MAX || acc < S32_MIN) begin
            acc = clip32(acc);
            r.status = ST_SAT;
          end
          r.value = acc[31:0];
        end
        owed_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int gap_length();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: presents the backlog on in_ch; the shadow model sees each beat
  // at the edge where it is accepted.
  beat_t cur_beat;
  int    send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    logic showing;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= CMD_LOAD;
      in_ch.x_value <= '0;
      in_ch.y_value <= '0;
      send_gap = 0;
    end else begin
      showing = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        apply_beat(cur_beat);
        showing = 1'b0;
      end
      if (!showing) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() > 0) begin
          cur_beat = cmd_backlog.pop_front();
          in_ch.cmd <= cur_beat.cmd;
          in_ch.x_value <= cur_beat.x_value;
          in_ch.y_value <= cur_beat.y_value;
          showing = 1'b1;
          send_gap = gap_length();
        end
      end
      in_ch.valid <= showing;
    end
  end

  // Monitor: random back-pressure on out_ch and in-order comparison.
  int sink_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: value %h status %0d",
                     out_ch.value, out_ch.status);
        end else begin
          want = owed_results.pop_front();
          if (out_ch.value !== want.value || out_ch.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected value %h status %0d, got %h status %0d",
                       want.value, want.status, out_ch.value, out_ch.status);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        sink_gap = gap_length();
      end
    end
  end

  task automatic queue_beat(logic [1:0] c, longint x, longint y);
    beat_t b;
    b.cmd = c;
    b.x_value = x[31:0];
    b.y_value = y[31:0];
    cmd_backlog.push_back(b);
    if (c != CMD_SPARE) beats_queued++;
  endtask

  // Waits until every beat has gone in and every result has come out, then
  // lets any set-up that a final load started run to its end.
  task automatic wait_until_quiet();
    while (cmd_backlog.size() != 0 || in_ch.valid || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == CFG_DEGREE) begin
      sh_degree = data[2:0];
      sh_loaded = 0;
      sh_ready = 1'b0;
      sh_even = 1'b1;
    end else begin
      sh_tol = data;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic longint rand_s32();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint rand_ordinate();
    if ($urandom_range(0, 9) == 0) return rand_s32();
    return longint'($urandom_range(0, 1 << 22)) - (1 << 21);
  endfunction

  // Loads one full point set in shuffled order. Shape 0 is evenly spaced,
  // shape 1 repeats an abscissa, shape 2 jitters the spacing around the
  // tolerance so that both sides of the limit are seen.
  task automatic load_point_set(int shape, longint x0, longint h);
    int     np, k;
    longint xs[MAX_POINTS];
    longint tmp;
    np = point_count();
    for (int i = 0; i < np; i++) begin
      xs[i] = x0 + longint'(i) * h;
      if (shape == 2 && i >= 2)
        xs[i] += longint'($urandom_range(0, 2 * sh_tol + 2)) - sh_tol - 1;
    end
    if (shape == 1) xs[$urandom_range(1, np - 1)] = xs[0];
    for (int i = np - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = xs[i]; xs[i] = xs[k]; xs[k] = tmp;
    end
    for (int i = 0; i < np; i++) queue_beat(CMD_LOAD, xs[i], rand_ordinate());
  endtask

  function automatic longint near_abscissa(longint x0, longint h);
    if ($urandom_range(0, 9) == 0) return rand_s32();
    return x0 + (longint'($urandom_range(0, (point_count() + 3) * 1000)) - 1000)
                * h / 1000;
  endfunction

  initial begin
    int     shape, evals, deg;
    longint x0, h;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_DEGREE;
    cfg_data_i = '0;
    mismatches = 0;
    beats_queued = 0;
    no_idle = 1'b0;
    sh_degree = 3'd1;
    sh_tol = 16'd1;
    sh_loaded = 0;
    sh_ready = 1'b0;
    sh_even = 1'b1;
    for (int i = 0; i < MAX_POINTS; i++) begin
      sh_x[i] = 0; sh_y[i] = 0; sh_coef[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset settings: evaluate before any point, the
    // spare command, the extremes of every field, a load into a full set,
    // equal abscissae and a spacing so wide that h itself overflows.
    queue_beat(CMD_EVAL, 0, 0);
    queue_beat(CMD_SPARE, -1, -1);
    queue_beat(CMD_LOAD, 0, 0);
    queue_beat(CMD_LOAD, 1 << 16, S32_MAX);
    queue_beat(CMD_EVAL, S32_MAX, 0);
    queue_beat(CMD_EVAL, S32_MIN, -1);
    queue_beat(CMD_EVAL, 1 << 15, 0);
    queue_beat(CMD_LOAD, 5, 5);
    queue_beat(CMD_EVAL, 3 << 16, 0);
    queue_beat(CMD_CLEAR, 0, 0);
    queue_beat(CMD_LOAD, 7 << 16, 1);
    queue_beat(CMD_LOAD, 7 << 16, 2);
    queue_beat(CMD_EVAL, 7 << 16, 0);
    queue_beat(CMD_CLEAR, S32_MIN, S32_MIN);
    queue_beat(CMD_LOAD, S32_MAX, S32_MIN);
    queue_beat(CMD_LOAD, S32_MIN, S32_MAX);
    queue_beat(CMD_EVAL, 0, 0);
    queue_beat(CMD_EVAL, S32_MIN, 0);
    wait_until_quiet();

    // Top degree with zero tolerance, points given in falling order.
    write_reg(CFG_DEGREE, 16'd7);
    write_reg(CFG_TOL, 16'd0);
    for (int i = 7; i >= 0; i--)
      queue_beat(CMD_LOAD, longint'(i) << 16, (i % 2) ? S32_MAX : S32_MIN);
    queue_beat(CMD_EVAL, 3 << 15, 0);
    queue_beat(CMD_EVAL, 40 << 16, 0);
    queue_beat(CMD_EVAL, -(1 << 16), 0);
    wait_until_quiet();

    // Random phases: a new setting, two point sets, evaluations around each and
    // some noise. Each phase ends with the sender held until all is in.
    while (beats_queued < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 5) == 0);
      deg = $urandom_range(0, 7);
      write_reg(CFG_DEGREE, {13'($urandom_range(0, 8191)), 3'(deg)});
      case ($urandom_range(0, 5))
        0: write_reg(CFG_TOL, 16'd0);
        1: write_reg(CFG_TOL, 16'hffff);
        2: write_reg(CFG_TOL, 16'($urandom_range(0, 64)));
        default: write_reg(CFG_TOL, 16'($urandom_range(0, 65535)));
      endcase
      for (int rep = 0; rep < 2; rep++) begin
        shape = $urandom_range(0, 9);
        shape = shape < 7 ? 0 : (shape < 8 ? 1 : 2);
        x0 = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
        h = $urandom_range(0, 3) == 0 ? longint'($urandom_range(1, 1 << 12))
                                      : longint'($urandom_range(1 << 12, 4 << 16));
        if ($urandom_range(0, 3) == 0)
          queue_beat(CMD_EVAL, x0, rand_s32());
        load_point_set(shape, x0, h);
        evals = $urandom_range(3, 8);
        for (int e = 0; e < evals; e++) begin
          if ($urandom_range(0, 7) == 0)
            queue_beat($urandom_range(0, 1) ? CMD_LOAD : CMD_SPARE,
                       rand_s32(), rand_s32());
          queue_beat(CMD_EVAL, near_abscissa(x0, h), rand_s32());
        end
        queue_beat(CMD_CLEAR, rand_s32(), rand_s32());
        if ($urandom_range(0, 2) == 0) begin
          for (int p = $urandom_range(0, point_count() - 1); p > 0; p--)
            queue_beat(CMD_LOAD, rand_s32(), rand_s32());
          queue_beat(CMD_EVAL, rand_s32(), rand_s32());
          queue_beat(CMD_CLEAR, 0, 0);
        end
      end
      wait_until_quiet();
    end

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(20ns * 8000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/nfi_pkg.sv
hw/rtl/nfi_channels.sv
hw/rtl/nfi_div.sv
hw/rtl/newton_forward_interpolator.sv
hw/rtl/nfi_checker.sv
tb/sv/newton_forward_interpolator_tb.sv
